>>> rtl/core/awb_pkg.sv
// ---------------------------------------------------------------------------
// awb_pkg
// Shared types and constants of the affine warp unit.
// ---------------------------------------------------------------------------
package awb_pkg;

    localparam int unsigned MISS_W   = 17;
    localparam logic [16:0] MISS_MAX = 17'd65536;

    localparam logic [2:0] REG_ACROSS_X = 3'd0;
    localparam logic [2:0] REG_ACROSS_Y = 3'd1;
    localparam logic [2:0] REG_DOWN_X   = 3'd2;
    localparam logic [2:0] REG_DOWN_Y   = 3'd3;
    localparam logic [2:0] REG_START_X  = 3'd4;
    localparam logic [2:0] REG_START_Y  = 3'd5;
    localparam logic [2:0] REG_WIDTH    = 3'd6;
    localparam logic [2:0] REG_HEIGHT   = 3'd7;

    // Neighbor select: top left, top right, bottom left, bottom right.
    localparam logic [1:0] NB_TL = 2'd0;
    localparam logic [1:0] NB_TR = 2'd1;
    localparam logic [1:0] NB_BL = 2'd2;
    localparam logic [1:0] NB_BR = 2'd3;

    typedef enum logic [3:0] {
        t_ST_IDLE,
        t_ST_MULX,
        t_ST_SUM,
        t_ST_RD0,
        t_ST_RD1,
        t_ST_RD2,
        t_ST_RD3,
        t_ST_LAST,
        t_ST_BLX,
        t_ST_BLY,
        t_ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic rd;
        logic [1:0] rd_sel;
        logic blx;
        logic bly;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic in_area;
        logic is_req;
        logic req_ok;
    } t_status;

endpackage

>>> rtl/core/affine_warp_bilinear_unit.sv
// ---------------------------------------------------------------------------
// affine_warp_bilinear_unit
// Affine image warp of an 8-bit grey frame with bilinear interpolation.
// ---------------------------------------------------------------------------
// A pixel write (tuser 0) is taken and lands in the frame store; it produces
// no result and the next item can follow in the next cycle. A warp request
// (tuser 1) shows its result on the master side after these steps: multiply,
// sum and range check, then four single-port reads of the frame store for the
// neighbors, a step for the last read data, the horizontal blend and the
// vertical blend. A request whose position falls outside the valid area skips
// the reads and blends and shows its fill result after the multiply, sum and
// range check. The next item is taken the cycle after the result is taken;
// the four reads through the single read port set the pace. A request with
// an out-of-range output position is dropped without a result. No item is
// accepted while a result waits.
module affine_warp_bilinear_unit #(
    parameter int unsigned MAX_SRC_WIDTH  = 256,
    parameter int unsigned MAX_SRC_HEIGHT = 256,
    parameter int unsigned FILL_VALUE     = 0,
    parameter int unsigned MAX_OUT_SIZE   = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd
    input  logic        s_axis_tuser,
    // src_col[7:0], src_row[15:8], src_pixel[23:16], out_col[31:24],
    // out_row[39:32], frame_start[40], zero pad to 48
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // outside
    output logic        m_axis_tuser,
    // out_pixel[7:0], miss_count[24:8], zero pad to 32
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [27:0] i_cfg_data
);
    awb_pkg::t_cmd    w_cmd;
    awb_pkg::t_status w_status;
    logic [7:0]       w_pix;
    logic             w_out;
    logic [16:0]      w_miss;

    awb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(w_status), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .o_cmd(w_cmd)
    );

    awb_dp #(
        .MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
        .FILL_VALUE(FILL_VALUE), .MAX_OUT_SIZE(MAX_OUT_SIZE)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_cmd_bit(s_axis_tuser), .i_src_col(s_axis_tdata[7:0]),
        .i_src_row(s_axis_tdata[15:8]), .i_src_pixel(s_axis_tdata[23:16]),
        .i_out_col(s_axis_tdata[31:24]), .i_out_row(s_axis_tdata[39:32]),
        .i_frame_start(s_axis_tdata[40]),
        .i_cmd(w_cmd), .o_status(w_status),
        .o_out_pixel(w_pix), .o_outside(w_out), .o_miss_count(w_miss)
    );

    assign m_axis_tdata = {7'd0, w_miss, w_pix};
    assign m_axis_tuser = w_out;
endmodule

>>> rtl/core/awb_ram.sv
// ---------------------------------------------------------------------------
// awb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module awb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/awb_ctrl.sv
// ---------------------------------------------------------------------------
// awb_ctrl
// Sequencer: issues one command per step of a warp request.
// ---------------------------------------------------------------------------
module awb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  awb_pkg::t_status  i_status,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output awb_pkg::t_cmd     o_cmd
);
    awb_pkg::t_state r_state, n_state;
    logic            w_acc;

    assign w_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            awb_pkg::t_ST_IDLE:
                if (w_acc && i_status.is_req && i_status.req_ok) n_state = awb_pkg::t_ST_MULX;
            awb_pkg::t_ST_MULX: n_state = awb_pkg::t_ST_SUM;
            awb_pkg::t_ST_SUM:  n_state = awb_pkg::t_ST_RD0;
            awb_pkg::t_ST_RD0:
                n_state = i_status.in_area ? awb_pkg::t_ST_RD1 : awb_pkg::t_ST_OUT;
            awb_pkg::t_ST_RD1:  n_state = awb_pkg::t_ST_RD2;
            awb_pkg::t_ST_RD2:  n_state = awb_pkg::t_ST_RD3;
            awb_pkg::t_ST_RD3:  n_state = awb_pkg::t_ST_LAST;
            awb_pkg::t_ST_LAST: n_state = awb_pkg::t_ST_BLX;
            awb_pkg::t_ST_BLX:  n_state = awb_pkg::t_ST_BLY;
            awb_pkg::t_ST_BLY:  n_state = awb_pkg::t_ST_OUT;
            awb_pkg::t_ST_OUT:
                if (i_out_ready) n_state = awb_pkg::t_ST_IDLE;
            default: n_state = awb_pkg::t_ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            awb_pkg::t_ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = w_acc;
            end
            awb_pkg::t_ST_MULX: o_cmd.mul = 1'b1;
            awb_pkg::t_ST_SUM:  o_cmd.sum = 1'b1;
            awb_pkg::t_ST_RD0: begin
                o_cmd.rd     = i_status.in_area;
                o_cmd.rd_sel = awb_pkg::NB_TL;
                o_cmd.fin    = !i_status.in_area;
            end
            awb_pkg::t_ST_RD1: begin o_cmd.rd = 1'b1; o_cmd.rd_sel = awb_pkg::NB_TR; end
            awb_pkg::t_ST_RD2: begin o_cmd.rd = 1'b1; o_cmd.rd_sel = awb_pkg::NB_BL; end
            awb_pkg::t_ST_RD3: begin o_cmd.rd = 1'b1; o_cmd.rd_sel = awb_pkg::NB_BR; end
            awb_pkg::t_ST_LAST: o_cmd.rd_sel = awb_pkg::NB_BR;
            awb_pkg::t_ST_BLX:  o_cmd.blx = 1'b1;
            awb_pkg::t_ST_BLY:  o_cmd.bly = 1'b1;
            awb_pkg::t_ST_OUT:  o_out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= awb_pkg::t_ST_IDLE;
        else          r_state <= n_state;
    end

    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_state == awb_pkg::t_ST_OUT) else $error("out valid outside OUT");
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid together");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
endmodule

>>> rtl/core/awb_dp.sv
// ---------------------------------------------------------------------------
// awb_dp
// Datapath: config registers, position math, frame store, bilinear blend.
// ---------------------------------------------------------------------------
module awb_dp #(
    parameter int unsigned MAX_SRC_WIDTH  = 256,
    parameter int unsigned MAX_SRC_HEIGHT = 256,
    parameter int unsigned FILL_VALUE     = 0,
    parameter int unsigned MAX_OUT_SIZE   = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [27:0]       i_cfg_data,
    input  logic              i_cmd_bit,
    input  logic [7:0]        i_src_col,
    input  logic [7:0]        i_src_row,
    input  logic [7:0]        i_src_pixel,
    input  logic [7:0]        i_out_col,
    input  logic [7:0]        i_out_row,
    input  logic              i_frame_start,
    input  awb_pkg::t_cmd     i_cmd,
    output awb_pkg::t_status  o_status,
    output logic [7:0]        o_out_pixel,
    output logic              o_outside,
    output logic [16:0]       o_miss_count
);
    localparam int unsigned CW = $clog2(MAX_SRC_WIDTH);
    localparam int unsigned RW = $clog2(MAX_SRC_HEIGHT);
    localparam int unsigned AW = CW + RW;
    localparam int unsigned DEPTH = 1 << AW;

    logic signed [23:0] r_ax, r_ay, r_dx, r_dy;
    logic signed [27:0] r_sx, r_sy;
    logic [8:0]         r_w, r_h;
    logic [16:0]        r_miss;

    logic signed [8:0]  r_oc, r_or;
    logic signed [33:0] r_cx, r_cy, r_rx, r_ry;
    logic signed [35:0] r_px, r_py;
    logic               r_in;
    logic [7:0]         r_a, r_b, r_c;
    logic [23:0]        r_top, r_bot;
    logic [7:0]         r_pix;
    logic               r_out;

    logic               w_we, w_wok;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [7:0]         w_rdata;
    logic [12:0]        w_we_cap, w_he_cap;
    logic signed [35:0] w_xb, w_yb, w_px, w_py;
    logic [CW:0]        w_lx;
    logic [RW:0]        w_ly;
    logic [16:0]        w_fx, w_fy, w_gx, w_gy;
    logic [40:0]        w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= 24'sd65536; r_ay <= '0; r_dx <= '0; r_dy <= 24'sd65536;
            r_sx <= '0; r_sy <= '0; r_w <= 9'd256; r_h <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                awb_pkg::REG_ACROSS_X: r_ax <= i_cfg_data[23:0];
                awb_pkg::REG_ACROSS_Y: r_ay <= i_cfg_data[23:0];
                awb_pkg::REG_DOWN_X:   r_dx <= i_cfg_data[23:0];
                awb_pkg::REG_DOWN_Y:   r_dy <= i_cfg_data[23:0];
                awb_pkg::REG_START_X:  r_sx <= i_cfg_data;
                awb_pkg::REG_START_Y:  r_sy <= i_cfg_data;
                awb_pkg::REG_WIDTH:    r_w  <= i_cfg_data[8:0];
                awb_pkg::REG_HEIGHT:   r_h  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign o_status.is_req  = i_cmd_bit;
    assign o_status.req_ok  = (32'(i_out_col) < MAX_OUT_SIZE) && (32'(i_out_row) < MAX_OUT_SIZE);
    assign o_status.in_area = r_in;

    // Pixel writes are done at accept and do not step the sequencer.
    assign w_wok   = (32'(i_src_col) < MAX_SRC_WIDTH) && (32'(i_src_row) < MAX_SRC_HEIGHT);
    assign w_we    = i_cmd.load && !i_cmd_bit && w_wok;
    assign w_waddr = {RW'(i_src_row), CW'(i_src_col)};

    assign w_we_cap = (32'(r_w) > MAX_SRC_WIDTH)  ? 13'(MAX_SRC_WIDTH)  : 13'(r_w);
    assign w_he_cap = (32'(r_h) > MAX_SRC_HEIGHT) ? 13'(MAX_SRC_HEIGHT) : 13'(r_h);
    assign w_xb = 36'(signed'({1'b0, w_we_cap}) - 14'sd1) <<< 16;
    assign w_yb = 36'(signed'({1'b0, w_he_cap}) - 14'sd1) <<< 16;
    assign w_px = 36'(r_sx) + 36'(r_cx) + 36'(r_rx);
    assign w_py = 36'(r_sy) + 36'(r_cy) + 36'(r_ry);

    assign w_lx = r_px[16 +: CW+1];
    assign w_ly = r_py[16 +: RW+1];
    assign w_fx = {1'b0, r_px[15:0]};
    assign w_fy = {1'b0, r_py[15:0]};
    assign w_gx = 17'd65536 - w_fx;
    assign w_gy = 17'd65536 - w_fy;

    always_comb begin
        case (i_cmd.rd_sel)
            awb_pkg::NB_TL: w_raddr = {w_ly[RW-1:0], w_lx[CW-1:0]};
            awb_pkg::NB_TR: w_raddr = {w_ly[RW-1:0], CW'(w_lx + 1'b1)};
            awb_pkg::NB_BL: w_raddr = {RW'(w_ly + 1'b1), w_lx[CW-1:0]};
            default: w_raddr = {RW'(w_ly + 1'b1), CW'(w_lx + 1'b1)};
        endcase
    end

    awb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we),
        .i_waddr(w_waddr),
        .i_wdata(i_src_pixel), .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    assign w_sum = 41'(w_gy) * 41'(r_top) + 41'(w_fy) * 41'(r_bot);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_oc <= signed'({1'b0, i_out_col});
            r_or <= signed'({1'b0, i_out_row});
        end
        if (i_cmd.mul) begin
            r_cx <= r_oc * r_ax; r_cy <= r_oc * r_ay;
            r_rx <= r_or * r_dx; r_ry <= r_or * r_dy;
        end
        if (i_cmd.sum) begin
            r_px <= w_px; r_py <= w_py;
            r_in <= (w_px >= 0) && (w_py >= 0) && (w_px < w_xb) && (w_py < w_yb);
        end
        // Read data arrives in the cycle after its address.
        if (i_cmd.rd) begin
            case (i_cmd.rd_sel)
                awb_pkg::NB_TR: r_a <= w_rdata;
                awb_pkg::NB_BL: r_b <= w_rdata;
                awb_pkg::NB_BR: r_c <= w_rdata;
                default: ;
            endcase
        end
        if (i_cmd.blx) begin
            r_top <= 24'(w_gx) * 24'(r_a) + 24'(w_fx) * 24'(r_b);
            r_bot <= 24'(w_gx) * 24'(r_c) + 24'(w_fx) * 24'(w_rdata);
        end
        if (i_cmd.bly) begin
            r_pix <= w_sum[39:32];
            r_out <= 1'b0;
        end else if (i_cmd.fin) begin
            r_pix <= 8'(FILL_VALUE);
            r_out <= 1'b1;
        end
    end

    // Clear on frame start at accept, count misses as they resolve.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss <= '0;
        end else if (i_cmd.load && i_cmd_bit && o_status.req_ok && i_frame_start) begin
            r_miss <= '0;
        end else if (i_cmd.fin && r_miss < awb_pkg::MISS_MAX) begin
            r_miss <= r_miss + 17'd1;
        end
    end

    assign o_out_pixel  = r_pix;
    assign o_outside    = r_out;
    assign o_miss_count = r_miss;

    a_miss_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_miss <= awb_pkg::MISS_MAX) else $error("miss count overflow");
    a_fin_not_bl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.fin && i_cmd.bly)) else $error("fill and blend together");
    a_fill_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> r_out) else $error("fill without outside flag");
endmodule

>>> sim/affine_warp_bilinear_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// affine_warp_bilinear_checker
// Watches both stream channels and the register port of the warp unit,
// predicts each warped pixel with its own copy of the frame store, the
// registers and the miss counter, and compares every result field by field.
// ---------------------------------------------------------------------------
module affine_warp_bilinear_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_in_user,
    input  logic [47:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_out_user,
    input  logic [31:0] i_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [27:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [16:0] miss;
        logic        outside;
        logic [7:0]  pixel;
    } t_warp_result;

    logic [7:0]   frame_mem [0:65535];
    logic [27:0]  warp_reg  [0:7];
    logic [16:0]  miss_cnt;
    t_warp_result warp_q [$];

    assign o_pending = warp_q.size();

    function automatic t_warp_result warp_pixel(input logic [7:0] col, input logic [7:0] row,
                                                input logic clr);
        t_warp_result res;
        longint px, py, xb, yb, fx, fy, top, bot, sum;
        int w, h, lx, ly;
        w  = (warp_reg[awb_pkg::REG_WIDTH][8:0] > 9'd256) ? 256
           : int'(warp_reg[awb_pkg::REG_WIDTH][8:0]);
        h  = (warp_reg[awb_pkg::REG_HEIGHT][8:0] > 9'd256) ? 256
           : int'(warp_reg[awb_pkg::REG_HEIGHT][8:0]);
        if (clr) miss_cnt = '0;
        px = longint'($signed(warp_reg[awb_pkg::REG_START_X]))
           + longint'(col) * longint'($signed(warp_reg[awb_pkg::REG_ACROSS_X][23:0]))
           + longint'(row) * longint'($signed(warp_reg[awb_pkg::REG_DOWN_X][23:0]));
        py = longint'($signed(warp_reg[awb_pkg::REG_START_Y]))
           + longint'(col) * longint'($signed(warp_reg[awb_pkg::REG_ACROSS_Y][23:0]))
           + longint'(row) * longint'($signed(warp_reg[awb_pkg::REG_DOWN_Y][23:0]));
        xb = longint'(w - 1) * 65536;
        yb = longint'(h - 1) * 65536;
        if (px >= 0 && py >= 0 && px < xb && py < yb) begin
            lx  = int'(px >>> 16);
            ly  = int'(py >>> 16);
            fx  = px & 16'hFFFF;
            fy  = py & 16'hFFFF;
            top = (65536 - fx) * frame_mem[ly*256 + lx] + fx * frame_mem[ly*256 + lx + 1];
            bot = (65536 - fx) * frame_mem[(ly+1)*256 + lx]
                + fx * frame_mem[(ly+1)*256 + lx + 1];
            sum = (65536 - fy) * top + fy * bot;
            res.pixel   = 8'(sum >> 32);
            res.outside = 1'b0;
        end else begin
            res.pixel   = 8'(0);
            res.outside = 1'b1;
            if (miss_cnt < awb_pkg::MISS_MAX) miss_cnt++;
        end
        res.miss = miss_cnt;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_warp_result exp_res, got;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            miss_cnt     = '0;
            o_fail_count <= 0;
            warp_reg[0] = 28'd65536; warp_reg[1] = '0; warp_reg[2] = '0;
            warp_reg[3] = 28'd65536; warp_reg[4] = '0; warp_reg[5] = '0;
            warp_reg[6] = 28'd256;   warp_reg[7] = 28'd256;
            warp_q.delete();
        end else begin
            if (i_cfg_we) begin
                warp_reg[i_cfg_idx] = i_cfg_data;
            end
            // match the result before queuing a new one; accept needs an empty output
            if (i_out_valid && i_out_ready) begin
                got = t_warp_result'({i_out_data[24:8], i_out_user, i_out_data[7:0]});
                if (warp_q.size() == 0) begin
                    $error("unexpected result %h", i_out_data);
                    errs++;
                end else begin
                    exp_res = warp_q.pop_front();
                    if (got.pixel !== exp_res.pixel) begin
                        $error("out_pixel expected %0d actual %0d", exp_res.pixel, got.pixel);
                        errs++;
                    end
                    if (got.outside !== exp_res.outside) begin
                        $error("outside expected %0d actual %0d", exp_res.outside, got.outside);
                        errs++;
                    end
                    if (got.miss !== exp_res.miss) begin
                        $error("miss_count expected %0d actual %0d", exp_res.miss, got.miss);
                        errs++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (!i_in_user)
                    frame_mem[{i_in_data[15:8], i_in_data[7:0]}] = i_in_data[23:16];
                else
                    warp_q.push_back(warp_pixel(i_in_data[31:24], i_in_data[39:32],
                                                i_in_data[40]));
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

>>> sim/affine_warp_bilinear_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// affine_warp_bilinear_unit_tb
// Stimulus and verdict for the affine warp unit.
// ---------------------------------------------------------------------------
// Fill a 16 by 16 corner of the source frame first and keep the valid area
// inside it, so no read ever hits an unwritten pixel; then run directed
// requests and random phases under several matrix and size settings, with
// random gaps on the sender and random stalls on the receiver.
module affine_warp_bilinear_unit_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid, s_ready, s_user;
    // src_col, src_row, src_pixel, out_col, out_row, frame_start, pad
    logic [47:0] s_data;
    logic        m_valid, m_ready, m_user;
    // out_pixel, miss_count, pad
    logic [31:0] m_data;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [27:0] cfg_data;
    int          fail_count, pending;
    int          rx_wait;
    bit          rx_quiet;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    affine_warp_bilinear_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tuser(s_user), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tuser(m_user), .m_axis_tdata(m_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    affine_warp_bilinear_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_user(s_user), .i_in_data(s_data),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_user(m_user),
        .i_out_data(m_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: draw a random stall per result; none when quiet.
    always @(negedge i_clk) begin
        int draw;
        draw = $urandom_range(0, 5);
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (!m_valid) begin
            m_ready <= rx_quiet || (draw == 0);
            rx_wait <= draw;
        end else if (!m_ready) begin
            if (rx_quiet || rx_wait <= 1) m_ready <= 1'b1;
            else rx_wait <= rx_wait - 1;
        end
    end

    // Hold each item until accepted; optional random gap ahead of it.
    task automatic send_item(input logic user, input logic [47:0] item, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 5) : 0;
        repeat (gap) @(negedge i_clk);
        s_valid = 1'b1;
        s_user  = user;
        s_data  = item;
        do @(posedge i_clk); while (!(s_valid && s_ready));
        @(negedge i_clk);
        s_valid = 1'b0;
    endtask

    function automatic logic [47:0] pixel_write(input logic [7:0] col, input logic [7:0] row,
                                                input logic [7:0] val);
        return {7'd0, 1'b0, 8'd0, 8'd0, val, row, col};
    endfunction

    function automatic logic [47:0] warp_req(input logic [7:0] col, input logic [7:0] row,
                                             input logic clr);
        return {7'd0, clr, row, col, 8'd0, 8'd0, 8'd0};
    endfunction

    // Mostly small output positions so some land inside the small valid area.
    function automatic logic [7:0] rand_pos();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17));
    endfunction

    task automatic set_reg(input logic [2:0] idx, input logic [27:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Drain: wait for every result, then let the pipe settle (dropped requests).
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    // Random warp setting; mostly near identity/rotation, sometimes extremes.
    task automatic random_matrix();
        for (int r = 0; r < 4; r++)
            set_reg(3'(r), ($urandom_range(0, 7) == 0) ? 28'($urandom)
                           : 28'($signed(24'($urandom_range(0, 131072)) - 24'd65536)));
        set_reg(awb_pkg::REG_START_X, ($urandom_range(0, 5) == 0) ? 28'($urandom)
                                      : 28'($urandom_range(0, 16 << 16)));
        set_reg(awb_pkg::REG_START_Y, ($urandom_range(0, 5) == 0) ? 28'($urandom)
                                      : 28'($urandom_range(0, 16 << 16)));
        set_reg(awb_pkg::REG_WIDTH, 28'($urandom_range(0, 16)));
        set_reg(awb_pkg::REG_HEIGHT, 28'($urandom_range(0, 16)));
    endtask

    initial begin
        i_rst_n = 1'b0; s_valid = 1'b0; s_user = 1'b0; s_data = '0;
        cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0; rx_quiet = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill the 16 by 16 corner: every entry written once, fast, no gaps.
        for (int a = 0; a < 256; a++)
            send_item(1'b0, pixel_write(8'(a & 15), 8'(a >> 4), 8'($urandom)), 1'b0);

        // Directed: identity, edges of the valid area, corners.
        set_reg(awb_pkg::REG_WIDTH, 28'd16);
        set_reg(awb_pkg::REG_HEIGHT, 28'd16);
        send_item(1'b1, warp_req(8'd0, 8'd0, 1'b1), 1'b1);
        send_item(1'b1, warp_req(8'd14, 8'd14, 1'b0), 1'b1);
        send_item(1'b1, warp_req(8'd15, 8'd0, 1'b0), 1'b1);
        send_item(1'b1, warp_req(8'd0, 8'd15, 1'b0), 1'b1);
        send_item(1'b1, warp_req(8'd255, 8'd255, 1'b1), 1'b1);
        send_item(1'b0, pixel_write(8'd255, 8'd255, 8'd255), 1'b1);
        send_item(1'b0, pixel_write(8'd0, 8'd0, 8'd0), 1'b1);
        drain();
        // Half-pixel steps exercise the blend; size 0 and 1 leave no valid area.
        set_reg(awb_pkg::REG_ACROSS_X, 28'd32768);
        set_reg(awb_pkg::REG_DOWN_Y, 28'd98304);
        set_reg(awb_pkg::REG_START_X, 28'd12345);
        set_reg(awb_pkg::REG_START_Y, 28'd54321);
        send_item(1'b1, warp_req(8'd200, 8'd100, 1'b0), 1'b1);
        send_item(1'b1, warp_req(8'd7, 8'd3, 1'b0), 1'b1);
        drain();
        set_reg(awb_pkg::REG_WIDTH, 28'd0);
        send_item(1'b1, warp_req(8'd1, 8'd1, 1'b0), 1'b1);
        drain();
        set_reg(awb_pkg::REG_WIDTH, 28'd1);
        set_reg(awb_pkg::REG_HEIGHT, 28'd511);
        send_item(1'b1, warp_req(8'd1, 8'd1, 1'b0), 1'b1);
        drain();
        // Most negative and most positive matrix and start values.
        set_reg(awb_pkg::REG_WIDTH, 28'd2);
        set_reg(awb_pkg::REG_HEIGHT, 28'd2);
        set_reg(awb_pkg::REG_ACROSS_X, 28'h0800000);
        set_reg(awb_pkg::REG_ACROSS_Y, 28'h07FFFFF);
        set_reg(awb_pkg::REG_DOWN_X, 28'h07FFFFF);
        set_reg(awb_pkg::REG_DOWN_Y, 28'h0800000);
        set_reg(awb_pkg::REG_START_X, 28'h8000000);
        set_reg(awb_pkg::REG_START_Y, 28'h7FFFFFF);
        send_item(1'b1, warp_req(8'd255, 8'd255, 1'b0), 1'b1);
        send_item(1'b1, warp_req(8'd0, 8'd0, 1'b0), 1'b1);
        drain();
        set_reg(awb_pkg::REG_ACROSS_X, 28'd0); set_reg(awb_pkg::REG_ACROSS_Y, 28'd0);
        set_reg(awb_pkg::REG_DOWN_X, 28'd0);   set_reg(awb_pkg::REG_DOWN_Y, 28'd0);
        set_reg(awb_pkg::REG_START_X, 28'd65535); set_reg(awb_pkg::REG_START_Y, 28'd65535);
        send_item(1'b1, warp_req(8'd9, 8'd9, 1'b1), 1'b1);
        drain();

        // Random phases: mostly requests, some rewrites of pixels.
        for (int ph = 0; ph < 12; ph++) begin
            random_matrix();
            rx_quiet = (ph % 4 == 3);
            for (int n = 0; n < 135; n++) begin
                if ($urandom_range(0, 5) == 0)
                    send_item(1'b0, pixel_write(8'($urandom), 8'($urandom), 8'($urandom)),
                              ph % 4 != 2);
                else
                    send_item(1'b1, warp_req(rand_pos(), rand_pos(),
                                             $urandom_range(0, 19) == 0), ph % 4 != 2);
                // hold off until all results arrive, once per phase
                if (n == 67) while (pending != 0) @(negedge i_clk);
            end
            drain();
        end
        rx_quiet = 1'b1;
        drain();

        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/core/awb_pkg.sv
rtl/core/awb_ram.sv
rtl/core/awb_ctrl.sv
rtl/core/awb_dp.sv
rtl/core/affine_warp_bilinear_unit.sv
sim/affine_warp_bilinear_checker.sv
sim/affine_warp_bilinear_unit_tb.sv
